[rtl/htme_pkg.sv]
// Shared types, codes and sizes for the Huffman tree merge engine.
// Depends on nothing; the core refers to it by scoped names.
package htme_pkg;

   localparam int MAX_SYMBOLS = 256;
   localparam int DEPTH       = 256;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int ID_W        = 9;
   localparam int CNT_W       = ADDR_W + 1;
   localparam int WEIGHT_W    = 32;
   localparam int SYM_W       = 8;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_MERGE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_ONE_LEFT  = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_SATURATED = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [WEIGHT_W-1:0] weight;
      logic                leaf;
      logic [SYM_W-1:0]    symbol;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                is_root;
      logic [WEIGHT_W-1:0] sum_weight;
      logic [SYM_W-1:0]    right_symbol;
      logic [SYM_W-1:0]    left_symbol;
      logic                right_is_leaf;
      logic                left_is_leaf;
      logic [ID_W-1:0]     right_id;
      logic [ID_W-1:0]     left_id;
      logic [ID_W-1:0]     parent_id;
   } result_type;

endpackage

[rtl/huffman_tree_merge_engine_core.sv]
// Top level of the Huffman tree merge engine: command decode, list sequencer, result register.
// Depends on htme_pkg and on htme_ram, which holds the working list.
//
// Usage. Commands arrive on the req_ stream: req_tuser carries the command (load a leaf,
// merge once, clear), req_tdata the leaf symbol and weight. Every command yields exactly
// one transfer on the rsp_ stream, with the status in rsp_tuser and the merge report in
// rsp_tdata (all zero except the status for load, clear and refused merges).
// The list lives in one RAM used as a ring: a merge reads the two entries at the head,
// then walks the rest of the list, moving each entry not heavier than the parent one
// slot forward, and drops the parent into the gap it reaches.
// Latency: load, clear and refused merges answer in the cycle after their transfer.
// A merge reads the two head entries in S_LEFT and S_RGHT, then runs S_SRD and S_SEV once
// per remaining entry not heavier than the new parent, each of them costing one RAM read and
// one write back; the parent is written in S_SRD at the tail or in S_SEV before a heavier entry.
// Its result is valid in the cycle after the merge leaves S_DONE.
// The block handles one command at a time; req_tready drops while a merge walks the list.
// A result waits in the output register while the receiver stalls; a new command is
// taken in that cycle only if the register is being emptied, and a finished merge
// holds in its last state until the register frees up.
// Reset empties the list and restarts leaf and internal numbering; no clearing pass.
module huffman_tree_merge_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [39:0] req_tdata,   // symbol [7:0], weight [39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status
   output logic [79:0] rsp_tdata    // parent_id, left_id, right_id, left_is_leaf,
                                    // right_is_leaf, left_symbol, right_symbol,
                                    // sum_weight, is_root; zero fill on top
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LEFT = 3'd1;
   localparam logic [2:0] S_RGHT = 3'd2;
   localparam logic [2:0] S_SRD  = 3'd3;
   localparam logic [2:0] S_SEV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam int AW = htme_pkg::ADDR_W;
   localparam int CW = htme_pkg::CNT_W;
   localparam int IW = htme_pkg::ID_W;
   localparam int WW = htme_pkg::WEIGHT_W;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] leaves_ff, leaves_in;
   logic [IW-1:0] next_int_ff, next_int_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] rest_ff, rest_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   htme_pkg::result_type res_ff, res_in;
   htme_pkg::entry_type  left_ff, left_in;
   logic [WW-1:0] sum_ff, sum_in;
   logic          sat_ff, sat_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   htme_pkg::entry_type wr_data, rd_data, parent;
   logic          accept, rsp_free;
   logic [1:0]    cmd;
   logic [WW:0]   wide_sum;

   assign cmd      = req_tuser;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && rsp_free;
   assign accept   = req_tvalid && req_tready;
   assign wide_sum = {1'b0, left_ff.weight} + {1'b0, rd_data.weight};

   assign parent = '{id: next_int_ff, weight: sum_ff, leaf: 1'b0, symbol: '0};

   htme_ram #(.WIDTH(htme_pkg::ENTRY_W), .DEPTH(htme_pkg::DEPTH)) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      leaves_in    = leaves_ff;
      next_int_in  = next_int_ff;
      scan_in      = scan_ff;
      rest_in      = rest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      res_in       = res_ff;
      left_in      = left_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = parent;
      rd_en        = 1'b0;
      rd_addr      = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = htme_pkg::ST_OK;
               res_in       = '0;
               unique case (cmd)
                  htme_pkg::CMD_LOAD: begin
                     if (leaves_ff >= CW'(htme_pkg::MAX_SYMBOLS) ||
                         count_ff >= CW'(htme_pkg::DEPTH)) begin
                        status_in = htme_pkg::ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = head_ff + count_ff[AW-1:0];
                        wr_data   = '{id: IW'(leaves_ff), weight: req_tdata[39:8],
                                      leaf: 1'b1, symbol: req_tdata[7:0]};
                        count_in  = count_ff + 1'b1;
                        leaves_in = leaves_ff + 1'b1;
                     end
                  end
                  htme_pkg::CMD_MERGE: begin
                     if (count_ff == '0) begin
                        status_in = htme_pkg::ST_EMPTY;
                     end else if (count_ff == CW'(1)) begin
                        status_in = htme_pkg::ST_ONE_LEFT;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_en        = 1'b1;
                        rd_addr      = head_ff;
                        rest_in      = count_ff - CW'(2);
                        state_in     = S_LEFT;
                     end
                  end
                  htme_pkg::CMD_CLEAR: begin
                     count_in    = '0;
                     leaves_in   = '0;
                     head_in     = '0;
                     next_int_in = IW'(htme_pkg::MAX_SYMBOLS);
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LEFT: begin
            left_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = head_ff + AW'(1);
            state_in = S_RGHT;
         end
         S_RGHT: begin
            sat_in  = wide_sum[WW];
            sum_in  = wide_sum[WW] ? {WW{1'b1}} : wide_sum[WW-1:0];
            res_in.parent_id     = next_int_ff;
            res_in.left_id       = left_ff.id;
            res_in.right_id      = rd_data.id;
            res_in.left_is_leaf  = left_ff.leaf;
            res_in.right_is_leaf = rd_data.leaf;
            res_in.left_symbol   = left_ff.leaf ? left_ff.symbol : '0;
            res_in.right_symbol  = rd_data.leaf ? rd_data.symbol : '0;
            res_in.sum_weight    = wide_sum[WW] ? {WW{1'b1}} : wide_sum[WW-1:0];
            res_in.is_root       = (rest_ff == '0);
            scan_in  = '0;
            state_in = S_SRD;
         end
         S_SRD: begin
            if (scan_ff == rest_ff) begin
               // Reached the tail: the parent goes last.
               wr_en    = 1'b1;
               wr_addr  = head_ff + AW'(1) + scan_ff[AW-1:0];
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff + AW'(2) + scan_ff[AW-1:0];
               state_in = S_SEV;
            end
         end
         S_SEV: begin
            wr_en   = 1'b1;
            wr_addr = head_ff + AW'(1) + scan_ff[AW-1:0];
            if (rd_data.weight > sum_ff) begin
               state_in = S_DONE;
            end else begin
               wr_data  = rd_data;
               scan_in  = scan_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               status_in    = sat_ff ? htme_pkg::ST_SATURATED : htme_pkg::ST_OK;
               head_in      = head_ff + AW'(1);
               count_in     = rest_ff + 1'b1;
               next_int_in  = next_int_ff + 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         leaves_ff    <= '0;
         next_int_ff  <= IW'(htme_pkg::MAX_SYMBOLS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         leaves_ff    <= leaves_in;
         next_int_ff  <= next_int_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      rest_ff   <= rest_in;
      status_ff <= status_in;
      res_ff    <= res_in;
      left_ff   <= left_in;
      sum_ff    <= sum_in;
      sat_ff    <= sat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, res_ff};

   // The list never holds more entries than the RAM has rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(htme_pkg::DEPTH))
      else $error("list count beyond RAM depth");

   // A merge on two or more entries leaves idle, holds back its result and drops req_tready.
   a_merge_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == htme_pkg::CMD_MERGE && count_ff >= CW'(2))
      |=> (state_ff == S_LEFT && !req_tready))
      else $error("merge did not start");

   // The list walk never runs past the remaining entries.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRD || state_ff == S_SEV) |-> scan_ff <= rest_ff)
      else $error("scan index past list end");

   // The list changes length only on a completed transfer in or at the end of a merge.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (!accept && state_ff != S_DONE) |=> $stable(count_ff))
      else $error("list count changed while no command was active");

endmodule

[rtl/htme_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module htme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
